>>> design/first_fit_packing_with_conflicts_defines.svh
// assertion macros shared by the first-fit packing design
`ifndef FIRST_FIT_PACKING_WITH_CONFLICTS_DEFINES_SVH
`define FIRST_FIT_PACKING_WITH_CONFLICTS_DEFINES_SVH

// condition holds at every clock edge out of reset
`define FFPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("ffpc check failed");

// consequent holds in the same cycle as the antecedent
`define FFPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ffpc check failed");

// consequent holds in the cycle after the antecedent
`define FFPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ffpc check failed");

`endif

>>> design/ffpc_pkg.sv
// types and constants shared by the first-fit packing design
`timescale 1ns / 1ps

package ffpc_pkg;

    localparam int ITEM_ID_W  = 6;
    localparam int WEIGHT_W   = 16;
    localparam int MASK_W     = 64;
    localparam int IDX_OUT_W  = 6;
    localparam int CNT_OUT_W  = 7;

    localparam logic [WEIGHT_W-1:0] CAPACITY_RESET = 16'hFFFF;

    typedef struct packed {
        logic                 start_new;
        logic [ITEM_ID_W-1:0] item_id;
        logic [WEIGHT_W-1:0]  item_weight;
        logic [MASK_W-1:0]    conflict_mask;
    } t_in_item;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] bin_index;
        logic                 opened_new;
        logic [CNT_OUT_W-1:0] bins_in_use;
        logic                 overflow;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic advance;
        logic end_scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic fit;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

>>> design/ffpc_ctrl.sv
// controller state machine for the first-fit packing scan
`timescale 1ns / 1ps

module ffpc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ffpc_pkg::t_dp_status i_status,
    output ffpc_pkg::t_dp_cmd    o_cmd
);
    import ffpc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.fit || i_status.last) begin
                    o_cmd.end_scan = 1'b1;
                    n_state        = ST_COMMIT;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ST_COMMIT: begin
                // wait for the output slot before writing the bin back
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

>>> design/ffpc_datapath.sv
// bin store, scan index, fit test and result register for first-fit packing
`timescale 1ns / 1ps
`include "first_fit_packing_with_conflicts_defines.svh"

module ffpc_datapath #(
    parameter int MAX_BINS  = 64,
    parameter int MAX_ITEMS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [ffpc_pkg::WEIGHT_W-1:0]       i_cfg_data,
    input  ffpc_pkg::t_in_item                  i_in_item,
    input  ffpc_pkg::t_dp_cmd                   i_cmd,
    output ffpc_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output ffpc_pkg::t_out_item                 o_out_item
);
    import ffpc_pkg::*;

    localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int MEM_W = WEIGHT_W + MAX_ITEMS;

    // bin store: load in the upper bits, membership mask below
    logic [MEM_W-1:0]     r_mem [MAX_BINS];
    logic [MEM_W-1:0]     r_rd_data;
    logic [BIN_W-1:0]     rd_addr;
    logic [BIN_W-1:0]     wr_addr;
    logic [MEM_W-1:0]     wr_data;
    logic                 mem_we;

    logic [WEIGHT_W-1:0]  r_capacity;
    logic [CNT_W-1:0]     r_open;
    logic [CNT_W-1:0]     n_open;
    logic                 r_bin0_clear;
    logic [BIN_W-1:0]     r_idx;
    logic                 r_hit;
    logic [WEIGHT_W-1:0]  r_weight;
    logic [MAX_ITEMS-1:0] r_conflicts;
    logic [MAX_ITEMS-1:0] r_member_bit;
    logic [MAX_ITEMS-1:0] member_bit;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;

    logic [WEIGHT_W-1:0]  eff_load;
    logic [MAX_ITEMS-1:0] eff_members;
    logic [WEIGHT_W:0]    sum_w;
    logic [CNT_W-1:0]     idx_next_cnt;
    logic                 fit;
    logic                 last;
    logic                 full;

    // one-hot membership bit, empty for ids beyond the mask width
    always_comb begin
        for (int k = 0; k < MAX_ITEMS; k++) begin
            member_bit[k] = ({1'b0, i_in_item.item_id} == 7'(k));
        end
    end

    // bin 0 reads as empty until written after a reset or a start
    assign eff_load    = (r_bin0_clear && (r_idx == '0)) ? '0
                                                         : r_rd_data[MEM_W-1 -: WEIGHT_W];
    assign eff_members = (r_bin0_clear && (r_idx == '0)) ? '0
                                                         : r_rd_data[MAX_ITEMS-1:0];

    assign sum_w        = {1'b0, eff_load} + {1'b0, r_weight};
    assign fit          = (sum_w <= {1'b0, r_capacity}) && ((eff_members & r_conflicts) == '0);
    assign idx_next_cnt = CNT_W'(r_idx) + CNT_W'(1);
    assign last         = (idx_next_cnt == r_open);
    assign full         = (r_open == CNT_W'(MAX_BINS));

    assign o_status.fit      = fit;
    assign o_status.last     = last;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (i_cmd.advance) begin
            rd_addr = r_idx + BIN_W'(1);
        end else if (i_cmd.load_item) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_idx;
        end
    end

    assign mem_we  = i_cmd.commit && (r_hit || !full);
    assign wr_addr = r_hit ? r_idx : r_open[BIN_W-1:0];
    assign wr_data = r_hit ? {sum_w[WEIGHT_W-1:0], eff_members | r_member_bit}
                           : {r_weight, r_member_bit};
    assign n_open  = (!r_hit && !full) ? r_open + CNT_W'(1) : r_open;

    always_comb begin
        n_out.bins_in_use = CNT_OUT_W'(n_open);
        if (r_hit) begin
            n_out.bin_index  = IDX_OUT_W'(r_idx);
            n_out.opened_new = 1'b0;
            n_out.overflow   = 1'b0;
        end else if (full) begin
            n_out.bin_index  = '0;
            n_out.opened_new = 1'b0;
            n_out.overflow   = 1'b1;
        end else begin
            n_out.bin_index  = IDX_OUT_W'(r_open);
            n_out.opened_new = 1'b1;
            n_out.overflow   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_weight     <= i_in_item.item_weight;
            r_conflicts  <= i_in_item.conflict_mask[MAX_ITEMS-1:0];
            r_member_bit <= member_bit;
        end
        if (i_cmd.end_scan) begin
            r_hit <= fit;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAPACITY_RESET;
            r_open       <= CNT_W'(1);
            r_bin0_clear <= 1'b1;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (i_cmd.load_item) begin
                r_idx <= '0;
                if (i_in_item.start_new) begin
                    r_open       <= CNT_W'(1);
                    r_bin0_clear <= 1'b1;
                end
            end else if (i_cmd.advance) begin
                r_idx <= r_idx + BIN_W'(1);
            end
            if (i_cmd.commit) begin
                r_open <= n_open;
                if (r_hit && (r_idx == '0)) begin
                    r_bin0_clear <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `FFPC_ASSERT_ALWAYS(a_open_range, i_clk, i_rst_n, (r_open != '0) && (r_open <= CNT_W'(MAX_BINS)))
    `FFPC_ASSERT_ALWAYS(a_idx_below_open, i_clk, i_rst_n, CNT_W'(r_idx) < r_open)
    `FFPC_ASSERT_IMPL(a_drop_fields, i_clk, i_rst_n, r_out_valid && r_out.overflow, !r_out.opened_new && (r_out.bin_index == '0))
    `FFPC_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, i_cmd.commit, r_out_valid)

endmodule

>>> design/first_fit_packing_with_conflicts.sv
// top level of the first-fit bin packing block with item conflicts
// items arrive on i_in_valid / o_in_ready with payload i_in_item; each one is
// placed in the lowest open bin whose load plus weight stays within the
// capacity and has none of its conflicts, else a new bin opens or overflow is flagged
// results leave on o_out_valid / i_out_ready with payload o_out_item, one per item
// the user writes the capacity register (i_cfg_valid / o_cfg_ready / i_cfg_data)
// while the block is idle; not enforced by the block, o_cfg_ready is always high
// each item passes through the accept (idle), scan and commit states in that order;
// the scan checks 1 to MAX_BINS bins, from bin 0 up, stopping at the first that fits
// throughput is one item at a time: the scan walks the bin store through its
// single registered read port, one bin a cycle
// the next item is taken as soon as the commit has loaded the result register,
// even while that result still waits for i_out_ready
// if the receiver stalls, a finished item waits in the commit state until the
// result register empties
// reset (i_rst_n low, synchronous) sets the capacity to 65535 and leaves one
// empty bin 0 open; there is no clearing pass, unwritten bins are never scanned
`timescale 1ns / 1ps

module first_fit_packing_with_conflicts #(
    parameter int MAX_BINS  = 64,
    parameter int MAX_ITEMS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffpc_pkg::WEIGHT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ffpc_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ffpc_pkg::t_out_item           o_out_item
);
    import ffpc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    ffpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ffpc_datapath #(
        .MAX_BINS  (MAX_BINS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
